### hdl/msb_first_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// msb_first_bit_packer assertion macros
// Shared property shorthands for the bit packer RTL.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// mfbp_pkg
// Types and fixed constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mfbp_pkg;

	localparam int BYTE_W     = 8;
	localparam int WIDTH_W    = 7;
	localparam int VALUE_W    = 64;
	localparam int ADDR_OUT_W = 32;
	localparam int CAP_W      = 32;
	localparam int FREE_W     = 4;

	localparam logic              REQ_PUT     = 1'b0;
	localparam logic              REQ_FLUSH   = 1'b1;
	localparam logic              STATUS_OK   = 1'b0;
	localparam logic              STATUS_FULL = 1'b1;
	localparam logic [FREE_W-1:0] FREE_EMPTY  = 4'd8;
	localparam logic [CAP_W-1:0]  CAP_RESET   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_PACK
	} mfbp_state_t;

	// shift register controls
	typedef struct packed {
		logic load;
		logic flush;
		logic align;
		logic consume;
	} mfbp_sr_ctrl_t;

	// byte unit controls
	typedef struct packed {
		logic step;
		logic cfg_we;
	} mfbp_bu_ctrl_t;

	// byte unit outcome of one pack step
	typedef struct packed {
		logic                  complete;
		logic                  full;
		logic                  last;
		logic                  done;
		logic [BYTE_W-1:0]     data;
		logic [ADDR_OUT_W-1:0] addr;
	} mfbp_res_t;

endpackage

### hdl/mfbp_if.sv
// ----------------------------------------------------------------------------
// mfbp interfaces
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface mfbp_in_if;
	import mfbp_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [WIDTH_W-1:0] width_bits;
	logic [VALUE_W-1:0] value;

	modport source (output valid, req_type, width_bits, value, input ready);
	modport sink   (input valid, req_type, width_bits, value, output ready);
endinterface

interface mfbp_out_if;
	import mfbp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  byte_valid;
	logic [BYTE_W-1:0]     out_byte;
	logic [ADDR_OUT_W-1:0] byte_address;
	logic                  status;
	logic                  last;

	modport source (output valid, byte_valid, out_byte, byte_address, status, last,
		input ready);
	modport sink   (input valid, byte_valid, out_byte, byte_address, status, last,
		output ready);
endinterface

interface mfbp_cfg_if;
	import mfbp_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### hdl/mfbp_shreg.sv
// ----------------------------------------------------------------------------
// mfbp_shreg
// Request bit shift register: aligns the bits to the top, then hands them
// out one byte digit at a time.
// ----------------------------------------------------------------------------
module mfbp_shreg #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mfbp_pkg::mfbp_sr_ctrl_t             ctrl,
	input  logic [mfbp_pkg::WIDTH_W-1:0]        width_bits,
	input  logic [mfbp_pkg::VALUE_W-1:0]        value,
	input  logic [mfbp_pkg::FREE_W-1:0]         free,
	output logic [mfbp_pkg::BYTE_W-1:0]         top_byte,
	output logic [$clog2(MAX_WIDTH+1)-1:0]      remain,
	output logic                                align_done
);
	import mfbp_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int SH_W  = $clog2(MAX_WIDTH);

	logic [MAX_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]     rem_q;
	logic [SH_W-1:0]      sh_q;
	logic                 sh_big;

	assign sh_big     = CNT_W'(sh_q) >= CNT_W'(BYTE_W);
	assign align_done = !sh_big;
	assign top_byte   = val_q[MAX_WIDTH-1 -: BYTE_W];
	assign remain     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			sh_q  <= '0;
		end else if (ctrl.load) begin
			rem_q <= CNT_W'(width_bits);
			sh_q  <= SH_W'(CNT_W'(MAX_WIDTH) - CNT_W'(width_bits));
		end else if (ctrl.flush) begin
			rem_q <= CNT_W'(free);
			sh_q  <= '0;
		end else if (ctrl.align) begin
			if (sh_big) begin
				sh_q <= SH_W'(CNT_W'(sh_q) - CNT_W'(BYTE_W));
			end else begin
				sh_q <= '0;
			end
		end else if (ctrl.consume) begin
			rem_q <= rem_q - CNT_W'(free);
		end
	end

	// payload shift register
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= value[MAX_WIDTH-1:0];
		end else if (ctrl.flush) begin
			val_q <= '0;
		end else if (ctrl.align) begin
			if (sh_big) begin
				val_q <= val_q << BYTE_W;
			end else begin
				val_q <= val_q << sh_q[2:0];
			end
		end else if (ctrl.consume) begin
			val_q <= val_q << free;
		end
	end

endmodule

### hdl/mfbp_byte.sv
// ----------------------------------------------------------------------------
// mfbp_byte
// Partial byte, free count, byte address and capacity; forms one result
// per pack step.
// ----------------------------------------------------------------------------
module mfbp_byte #(
	parameter int MAX_WIDTH    = 64,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mfbp_pkg::mfbp_bu_ctrl_t             ctrl,
	input  logic [mfbp_pkg::CAP_W-1:0]          cfg_data,
	input  logic [mfbp_pkg::BYTE_W-1:0]         top_byte,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      remain,
	output logic [mfbp_pkg::FREE_W-1:0]         free,
	output mfbp_pkg::mfbp_res_t                 res
);
	import mfbp_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (ADDRESS_BITS > CAP_W) ? ADDRESS_BITS : CAP_W;

	logic [BYTE_W-1:0]       partial_q;
	logic [FREE_W-1:0]       free_q;
	logic [ADDRESS_BITS-1:0] pos_q;
	logic [CAP_W-1:0]        cap_q;

	logic [CMP_W-1:0]        cap_ext;
	logic [CMP_W-1:0]        pos_ext;
	logic [FREE_W-1:0]       drop;
	logic [BYTE_W-1:0]       merged;
	logic [BYTE_W-1:0]       resid;
	logic [BYTE_W-1:0]       keep_mask;
	logic [CNT_W-1:0]        rem_after;
	logic                    complete;
	logic                    full;

	assign free      = free_q;
	assign cap_ext   = CMP_W'(cap_q);
	assign pos_ext   = CMP_W'(pos_q);
	assign drop      = FREE_EMPTY - free_q;
	assign merged    = partial_q | (top_byte >> drop);
	assign keep_mask = ~(8'hFF >> remain[2:0]);
	assign resid     = partial_q | ((top_byte & keep_mask) >> drop);
	assign complete  = remain >= CNT_W'(free_q);
	assign full      = complete && (pos_q >= cap_ext[ADDRESS_BITS-1:0]);
	assign rem_after = remain - CNT_W'(free_q);

	always_comb begin
		res.complete = complete;
		res.full     = full;
		res.last     = full || (rem_after < CNT_W'(BYTE_W));
		res.done     = !complete || full;
		res.data     = full ? '0 : merged;
		res.addr     = pos_ext[ADDR_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			free_q    <= FREE_EMPTY;
			pos_q     <= '0;
			cap_q     <= CAP_RESET;
		end else begin
			if (ctrl.cfg_we) begin
				cap_q <= cfg_data;
			end
			if (ctrl.step) begin
				if (complete && full) begin
					// store full: keep merged bits, leave free and address alone
					partial_q <= merged;
				end else if (complete) begin
					partial_q <= '0;
					free_q    <= FREE_EMPTY;
					pos_q     <= pos_q + ADDRESS_BITS'(1);
				end else begin
					partial_q <= resid;
					free_q    <= free_q - FREE_W'(remain);
				end
			end
		end
	end

endmodule

### hdl/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// MSB-first bit packer: appends request bits to a byte stream and returns
// each completed byte with its address.
// ----------------------------------------------------------------------------
// Usage:
//   item   - requests: put (low width_bits of value) or flush (zero pad).
//   result - one request per completed byte, last marks the final one of an
//            item; a full store gives one request with status full.
//   cfg    - capacity_bytes write, always ready; write only while idle.
// Timing: the accepting cycle, then aligning a put of n bits in the shift
//   register (none for a flush), one pack step per completed byte and one
//   pack step to merge the leftover bits; a full store ends the item at
//   the refused byte. While aligning, one byte digit moves per cycle
//   through the shift register.
// Output: the first byte appears on result in the cycle after its pack step.
// Reset: partial byte cleared, eight free bits, address zero, capacity
//   all ones. Ignored requests (zero or oversize width, flush of an empty
//   byte) are taken and give no result.
// Stall: a single output register holds the result; a pack step that
//   completes a byte waits while it is occupied and not taken, and a new
//   item is taken once the last result sits in that register.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_macros.svh"

module msb_first_bit_packer #(
	parameter int MAX_WIDTH    = 64,
	parameter int ADDRESS_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mfbp_in_if.sink    item,
	mfbp_out_if.source result,
	mfbp_cfg_if.sink   cfg
);
	import mfbp_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH + 1);

	mfbp_state_t   state_q;
	mfbp_state_t   state_d;
	mfbp_sr_ctrl_t sr_ctrl;
	mfbp_bu_ctrl_t bu_ctrl;
	mfbp_res_t     res;

	logic [BYTE_W-1:0] top_byte;
	logic [CNT_W-1:0]  remain;
	logic [FREE_W-1:0] free;
	logic              align_done;
	logic              out_free;
	logic              item_rdy;
	logic              put_ok;

	logic                  ovalid_q;
	logic                  obv_q;
	logic [BYTE_W-1:0]     obyte_q;
	logic [ADDR_OUT_W-1:0] oaddr_q;
	logic                  ostat_q;
	logic                  olast_q;

	assign out_free = !ovalid_q || result.ready;
	assign put_ok   = (item.width_bits != '0) && (item.width_bits <= WIDTH_W'(MAX_WIDTH));

	assign cfg.ready      = 1'b1;
	assign item.ready     = item_rdy;

	mfbp_shreg #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_shreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sr_ctrl),
		.width_bits (item.width_bits),
		.value      (item.value),
		.free       (free),
		.top_byte   (top_byte),
		.remain     (remain),
		.align_done (align_done)
	);

	mfbp_byte #(
		.MAX_WIDTH    (MAX_WIDTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_byte (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (bu_ctrl),
		.cfg_data (cfg.data),
		.top_byte (top_byte),
		.remain   (remain),
		.free     (free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		item_rdy       = 1'b0;
		sr_ctrl        = '0;
		bu_ctrl        = '0;
		bu_ctrl.cfg_we = cfg.valid;
		case (state_q)
			ST_IDLE: begin
				item_rdy = 1'b1;
				if (item.valid) begin
					if (item.req_type == REQ_FLUSH) begin
						if (free != FREE_EMPTY) begin
							sr_ctrl.flush = 1'b1;
							state_d       = ST_PACK;
						end
					end else if (put_ok) begin
						sr_ctrl.load = 1'b1;
						state_d      = ST_ALIGN;
					end
				end
			end
			ST_ALIGN: begin
				sr_ctrl.align = 1'b1;
				if (align_done) begin
					state_d = ST_PACK;
				end
			end
			ST_PACK: begin
				// hold while a completed byte has nowhere to go
				if (!res.complete || out_free) begin
					bu_ctrl.step    = 1'b1;
					sr_ctrl.consume = res.complete && !res.full;
					if (res.done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (bu_ctrl.step && res.complete) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bu_ctrl.step && res.complete) begin
			obv_q   <= !res.full;
			obyte_q <= res.data;
			oaddr_q <= res.addr;
			ostat_q <= res.full ? STATUS_FULL : STATUS_OK;
			olast_q <= res.last;
		end
	end

	assign result.valid        = ovalid_q;
	assign result.byte_valid   = obv_q;
	assign result.out_byte     = obyte_q;
	assign result.byte_address = oaddr_q;
	assign result.status       = ostat_q;
	assign result.last         = olast_q;

	`MFBP_ASSERT_NOW(a_valid_xor_full, clk, arst_n, ovalid_q, obv_q != ostat_q,
		"written byte must carry ok status, refused byte full status")
	`MFBP_ASSERT_NEXT(a_full_ends_item, clk, arst_n,
		bu_ctrl.step && res.complete && res.full, state_q == ST_IDLE && olast_q,
		"full status must end the item")
	`MFBP_ASSERT_NOW(a_no_step_on_busy_out, clk, arst_n,
		ovalid_q && !result.ready && state_q == ST_PACK && res.complete,
		!bu_ctrl.step, "pack step taken while the result register is occupied")

endmodule
